### design/agt_pkg.sv
// Shared types, constants and coefficient tables for the gravity torque feedforward core.
// No dependencies; every other design file depends on this package.
package agt_pkg;

	localparam int ANGLE_IN_W = 16;
	localparam int TORQUE_W = 24;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int COS_FRAC_BITS_DEF = 15;

	// pipeline depth: cosine lanes, then the merge stages
	localparam int LANE_STAGES = 11;
	localparam int MERGE_STAGES = 5;
	localparam int PIPE_STAGES = LANE_STAGES + MERGE_STAGES;

	// round(2^32 / (2*pi)) and round(2*pi * 2^30)
	localparam logic signed [31:0] TURNS_PER_RAD = 32'sd683565276;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	// Taylor coefficients of cos, Q30, highest power first
	localparam logic signed [31:0] COS_COEF [0:6] = '{
		32'sd2, -32'sd296, 32'sd26631, -32'sd1491308,
		32'sd44739243, -32'sd536870912, 32'sd1073741824
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINK_MASS     = 3'd0,
		REG_MOTOR_MASS    = 3'd1,
		REG_CENTER_OFFSET = 3'd2,
		REG_LINK_LENGTH   = 3'd3,
		REG_GRAVITY       = 3'd4
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] LINK_MASS_RST = 16'd610;
	localparam logic [CFG_W-1:0] MOTOR_MASS_RST = 16'd1413;
	localparam logic [CFG_W-1:0] CENTER_OFFSET_RST = 16'd3932;
	localparam logic [CFG_W-1:0] LINK_LENGTH_RST = 16'd7864;
	localparam logic [CFG_W-1:0] GRAVITY_RST = 16'd2509;

	typedef struct packed {
		logic [CFG_W-1:0] link_mass;
		logic [CFG_W-1:0] motor_mass;
		logic [CFG_W-1:0] center_offset;
		logic [CFG_W-1:0] link_length;
		logic [CFG_W-1:0] gravity;
	} cfg_t;

endpackage

### design/agt_ifs.sv
// Valid/ready channel interfaces: angle input, torque output, register write.
// Depends on agt_pkg for field widths.
interface agt_angle_if;
	logic valid;
	logic ready;
	logic signed [agt_pkg::ANGLE_IN_W-1:0] angle_one;
	logic signed [agt_pkg::ANGLE_IN_W-1:0] angle_two;
	logic signed [agt_pkg::ANGLE_IN_W-1:0] angle_three;
	modport source (output valid, angle_one, angle_two, angle_three, input ready);
	modport sink (input valid, angle_one, angle_two, angle_three, output ready);
endinterface

interface agt_torque_if;
	logic valid;
	logic ready;
	logic signed [agt_pkg::TORQUE_W-1:0] torque_one;
	logic signed [agt_pkg::TORQUE_W-1:0] torque_two;
	logic signed [agt_pkg::TORQUE_W-1:0] torque_three;
	modport source (output valid, torque_one, torque_two, torque_three, input ready);
	modport sink (input valid, torque_one, torque_two, torque_three, output ready);
endinterface

interface agt_cfg_if;
	logic valid;
	logic ready;
	logic [agt_pkg::CFG_IDX_W-1:0] index;
	logic [agt_pkg::CFG_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/agt_cos_lane.sv
// One cosine lane: phase, quadrant fold, Taylor polynomial by Horner steps.
// Depends on agt_pkg; stage loads come from the top-level valid chain.
module agt_cos_lane #(
	parameter int ANGLE_FRAC_BITS = agt_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int COS_FRAC_BITS = agt_pkg::COS_FRAC_BITS_DEF,
	parameter int ANGLE_W = 19
) (
	input  logic clk,
	input  logic [agt_pkg::LANE_STAGES-1:0] en,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic signed [COS_FRAC_BITS+1:0] cos_val
);
	import agt_pkg::*;

	localparam int RS = 30 - COS_FRAC_BITS;

	logic signed [ANGLE_W+31:0] prod;
	logic [31:0] phase_s1;
	logic [32:0] pa, pf;
	logic fold_neg;
	logic [30:0] pf_s2;
	logic neg_s2;
	logic [63:0] xp;
	logic [30:0] x_s3;
	logic neg_s3;
	logic [61:0] sq;
	logic signed [31:0] acc_p [0:6];
	logic [31:0] x2_p [0:6];
	logic neg_p [0:6];
	logic [31:0] clamped;
	logic [31:0] rnd;
	logic [COS_FRAC_BITS:0] mag;

	// s1: phase in turns
	assign prod = angle * TURNS_PER_RAD;
	always_ff @(posedge clk) begin
		if (en[0]) phase_s1 <= prod[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
	end

	// s2: fold onto a quarter turn
	always_comb begin
		pa = phase_s1[31] ? (33'h1_0000_0000 - {1'b0, phase_s1}) : {1'b0, phase_s1};
		fold_neg = 1'b0;
		pf = pa;
		if (pa > 33'h0_4000_0000) begin
			pf = 33'h0_8000_0000 - pa;
			fold_neg = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pf_s2 <= pf[30:0];
			neg_s2 <= fold_neg;
		end
	end

	// s3: turns to radians, Q30
	assign xp = {33'b0, pf_s2} * TWO_PI_Q30;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			x_s3 <= xp[62:32];
			neg_s3 <= neg_s2;
		end
	end

	// s4: x squared
	assign sq = {31'b0, x_s3} * {31'b0, x_s3};
	always_ff @(posedge clk) begin
		if (en[3]) begin
			x2_p[0] <= sq[61:30];
			neg_p[0] <= neg_s3;
		end
	end
	assign acc_p[0] = COS_COEF[0];

	// s5..s10: acc = coef + acc*x2, product truncated toward zero
	for (genvar k = 1; k < 7; k++) begin : g_horner
		logic [31:0] amag;
		logic [63:0] mp;
		logic signed [34:0] term, sum;
		always_comb begin
			amag = acc_p[k-1][31] ? 32'(-acc_p[k-1]) : 32'(acc_p[k-1]);
			mp = {32'b0, amag} * {32'b0, x2_p[k-1]};
			term = acc_p[k-1][31] ? -$signed({1'b0, mp[63:30]}) : $signed({1'b0, mp[63:30]});
			sum = 35'(COS_COEF[k]) + term;
		end
		always_ff @(posedge clk) begin
			if (en[3+k]) begin
				acc_p[k] <= sum[31:0];
				x2_p[k] <= x2_p[k-1];
				neg_p[k] <= neg_p[k-1];
			end
		end
	end

	// s11: clamp to [0,1], round half up, apply fold sign
	always_comb begin
		if (acc_p[6] < 0) clamped = '0;
		else if (acc_p[6] > 32'sd1073741824) clamped = 32'd1073741824;
		else clamped = 32'(acc_p[6]);
		rnd = (clamped + (32'd1 << (RS - 1))) >> RS;
		mag = rnd[COS_FRAC_BITS:0];
	end
	always_ff @(posedge clk) begin
		if (en[10]) begin
			cos_val <= neg_p[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

endmodule

### design/agt_merge.sv
// Merge stage: weights the three lane cosines, rounds, scales by gravity, saturates.
// Depends on agt_pkg (cfg_t, widths).
module agt_merge #(
	parameter int COS_FRAC_BITS = agt_pkg::COS_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic [agt_pkg::MERGE_STAGES-1:0] en,
	input  agt_pkg::cfg_t cfg,
	input  logic signed [COS_FRAC_BITS+1:0] c0,
	input  logic signed [COS_FRAC_BITS+1:0] c1,
	input  logic signed [COS_FRAC_BITS+1:0] c2,
	output logic signed [agt_pkg::TORQUE_W-1:0] t0,
	output logic signed [agt_pkg::TORQUE_W-1:0] t1,
	output logic signed [agt_pkg::TORQUE_W-1:0] t2
);
	import agt_pkg::*;

	localparam int PW = COS_FRAC_BITS + 38;
	localparam int SW = PW + 2;
	localparam int QW = SW - COS_FRAC_BITS;
	localparam int GW = QW + 17;
	localparam int TW = GW - 19;

	function automatic logic signed [TORQUE_W-1:0] sat(input logic signed [TW-1:0] v);
		if (v > TW'(8388607)) return 24'sh7FFFFF;
		if (v < -TW'(8388608)) return -24'sh800000;
		return v[TORQUE_W-1:0];
	endfunction

	function automatic logic signed [QW-1:0] rnd_cos(input logic signed [SW-1:0] s);
		logic signed [SW:0] r;
		r = ($signed({s[SW-1], s}) + (SW+1)'(1 << (COS_FRAC_BITS - 1))) >>> COS_FRAC_BITS;
		return r[QW-1:0];
	endfunction

	function automatic logic signed [TW-1:0] rnd_grav(input logic signed [GW-1:0] g);
		logic signed [GW:0] r;
		r = ($signed({g[GW-1], g}) + (GW+1)'(1 << 19)) >>> 20;
		return r[TW-1:0];
	endfunction

	// link weights; static while items flow if the user holds cfg; not enforced
	logic [31:0] ka_q, kb_q, kc_q, kw2_q;
	logic [34:0] k0_q;
	logic [33:0] k1_q;
	always_ff @(posedge clk) begin
		ka_q <= cfg.link_mass * cfg.center_offset;
		kb_q <= cfg.motor_mass * cfg.link_length;
		kc_q <= cfg.link_mass * cfg.link_length;
		kw2_q <= ka_q;
		k0_q <= 35'(ka_q) + {2'b0, kb_q, 1'b0} + {2'b0, kc_q, 1'b0};
		k1_q <= 34'(ka_q) + 34'(kb_q) + 34'(kc_q);
	end

	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [SW-1:0] s0_s2, s1_s2, s2_s2;
	logic signed [QW-1:0] q0_s3, q1_s3, q2_s3;
	logic signed [GW-1:0] g0_s4, g1_s4, g2_s4;
	logic signed [TW-1:0] r1;

	assign r1 = rnd_grav(g1_s4);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p0_s1 <= $signed({1'b0, k0_q}) * c0;
			p1_s1 <= $signed({1'b0, k1_q}) * c1;
			p2_s1 <= $signed({1'b0, kw2_q}) * c2;
		end
		if (en[1]) begin
			s0_s2 <= SW'(p0_s1) + SW'(p1_s1) + SW'(p2_s1);
			s1_s2 <= SW'(p1_s1) + SW'(p2_s1);
			s2_s2 <= SW'(p2_s1);
		end
		if (en[2]) begin
			q0_s3 <= rnd_cos(s0_s2);
			q1_s3 <= rnd_cos(s1_s2);
			q2_s3 <= rnd_cos(s2_s2);
		end
		if (en[3]) begin
			g0_s4 <= q0_s3 * $signed({1'b0, cfg.gravity});
			g1_s4 <= q1_s3 * $signed({1'b0, cfg.gravity});
			g2_s4 <= q2_s3 * $signed({1'b0, cfg.gravity});
		end
		if (en[4]) begin
			t0 <= sat(rnd_grav(g0_s4));
			t1 <= sat(-r1);
			t2 <= sat(rnd_grav(g2_s4));
		end
	end

endmodule

### design/arm_gravity_torque_feedforward_core.sv
// Top level of the gravity holding-torque feedforward core for a three-link planar arm.
// Depends on agt_pkg, agt_ifs, agt_cos_lane and agt_merge.
//
// Usage:
//  - angles (sink): one transfer carries angle_one/two/three, signed Q3.12 rad.
//  - torques (source): one transfer carries torque_one/two/three, signed Q7.16 N*m,
//    saturated; torque_two comes out with its sign flipped.
//  - cfg (sink): register writes, index 0..4 = link_mass, motor_mass,
//    center_offset, link_length, gravity. Always ready; unknown indexes are dropped.
//    Write only while the pipeline is empty.
//  - Pipeline: 16 register stages (11 cosine lane stages, 5 merge stages);
//    the last merge stage is the output register that drives the result transfer.
//  - Throughput: one item per cycle while the receiver is ready; three cosine lanes run side by side.
//  - Stall: every stage holds a valid bit; a stage takes new data when it is
//    empty or the stage after it moves, so bubbles collapse and input keeps
//    flowing until the whole pipe is full behind a stalled receiver.
//  - Reset: clears the valid bits and loads the register reset values.
module arm_gravity_torque_feedforward_core #(
	parameter int ANGLE_FRAC_BITS = agt_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int COS_FRAC_BITS = agt_pkg::COS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	agt_angle_if.sink angles,
	agt_torque_if.source torques,
	agt_cfg_if.sink cfg
);
	import agt_pkg::*;

	// joint offset: round(1.57 rad)
	localparam int OFFSET = ((157 << ANGLE_FRAC_BITS) + 50) / 100;
	// absolute angle width: three raw angles plus the offset
	localparam int ANGLE_W = (ANGLE_FRAC_BITS + 3 > 19) ? ANGLE_FRAC_BITS + 3 : 19;

	// ---- configuration registers ----
	cfg_t cfg_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_mass <= LINK_MASS_RST;
			cfg_q.motor_mass <= MOTOR_MASS_RST;
			cfg_q.center_offset <= CENTER_OFFSET_RST;
			cfg_q.link_length <= LINK_LENGTH_RST;
			cfg_q.gravity <= GRAVITY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LINK_MASS:     cfg_q.link_mass <= cfg.data;
				REG_MOTOR_MASS:    cfg_q.motor_mass <= cfg.data;
				REG_CENTER_OFFSET: cfg_q.center_offset <= cfg.data;
				REG_LINK_LENGTH:   cfg_q.link_length <= cfg.data;
				REG_GRAVITY:       cfg_q.gravity <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---- valid chain: stage i loads when empty or stage i+1 loads ----
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES:0] en;
	assign en[PIPE_STAGES] = torques.ready;
	for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_en
		assign en[i] = ~vld_q[i] | en[i+1];
	end
	assign angles.ready = en[0];
	assign torques.valid = vld_q[PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= angles.valid;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// ---- absolute link angles: running sums of corrected joint angles ----
	logic signed [ANGLE_W-1:0] a0, a1, a2;
	assign a0 = ANGLE_W'(angles.angle_one) + ANGLE_W'(OFFSET);
	assign a1 = a0 - ANGLE_W'(angles.angle_two);
	assign a2 = a1 + ANGLE_W'(angles.angle_three);

	// ---- three cosine lanes ----
	logic signed [COS_FRAC_BITS+1:0] c0, c1, c2;
	logic [LANE_STAGES-1:0] lane_en;
	assign lane_en = en[LANE_STAGES-1:0];

	agt_cos_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .COS_FRAC_BITS(COS_FRAC_BITS),
		.ANGLE_W(ANGLE_W)) u_lane0 (.clk(clk), .en(lane_en), .angle(a0), .cos_val(c0));
	agt_cos_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .COS_FRAC_BITS(COS_FRAC_BITS),
		.ANGLE_W(ANGLE_W)) u_lane1 (.clk(clk), .en(lane_en), .angle(a1), .cos_val(c1));
	agt_cos_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .COS_FRAC_BITS(COS_FRAC_BITS),
		.ANGLE_W(ANGLE_W)) u_lane2 (.clk(clk), .en(lane_en), .angle(a2), .cos_val(c2));

	// ---- merge: weighting, gravity, saturation; last stage is the output register ----
	agt_merge #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_merge (
		.clk(clk),
		.en(en[PIPE_STAGES-1:LANE_STAGES]),
		.cfg(cfg_q),
		.c0(c0),
		.c1(c1),
		.c2(c2),
		.t0(torques.torque_one),
		.t1(torques.torque_two),
		.t2(torques.torque_three)
	);

endmodule

### design/agt_checker.sv
// Port-level checker for the gravity torque core, attached by bind.
// Depends on agt_pkg widths and the top level's interface ports.
module agt_checker (
	input logic clk,
	input logic arst_n,
	input logic angles_ready,
	input logic torques_valid,
	input logic torques_ready,
	input logic [agt_pkg::TORQUE_W-1:0] torque_one,
	input logic [agt_pkg::TORQUE_W-1:0] torque_two,
	input logic [agt_pkg::TORQUE_W-1:0] torque_three,
	input logic cfg_ready
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		torques_valid && !torques_ready |=> torques_valid && $stable(torque_one)
		&& $stable(torque_two) && $stable(torque_three))
		else $error("stalled torque result changed");

	// input never blocked when the output side can move
	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!torques_valid || torques_ready) |-> angles_ready)
		else $error("input stalled while output free");

	// register port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind arm_gravity_torque_feedforward_core agt_checker u_agt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.angles_ready(angles.ready),
	.torques_valid(torques.valid),
	.torques_ready(torques.ready),
	.torque_one(torques.torque_one),
	.torque_two(torques.torque_two),
	.torque_three(torques.torque_three),
	.cfg_ready(cfg.ready)
);
